// ===== sv/ibanv_pkg.sv =====
// Shared types, codes and mod-97 helpers of the IBAN mod-97 validator.
package ibanv_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_COUNTRY_FIRST   = 2'd0;
    localparam logic [1:0] CFG_COUNTRY_SECOND  = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_LENGTH = 2'd2;

    // status codes
    localparam logic [2:0] ST_VALID    = 3'd0;
    localparam logic [2:0] ST_COUNTRY  = 3'd1;
    localparam logic [2:0] ST_LENGTH   = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_BADCHAR  = 3'd4;

    localparam logic [7:0] CHAR_ZERO     = 8'd48;
    localparam logic [7:0] CHAR_NINE     = 8'd57;
    localparam logic [7:0] CHAR_A        = 8'd65;
    localparam logic [7:0] CHAR_Z        = 8'd90;
    localparam logic [7:0] LETTER_OFFSET = 8'd55;
    localparam logic [6:0] MODULUS       = 7'd97;
    localparam logic [5:0] HEAD_CHARS    = 6'd4;
    localparam logic [5:0] MIN_LENGTH    = 6'd5;
    localparam logic [5:0] COUNT_MAX     = 6'd63;

    // per-frame error flags, settled by the front and finished by the back
    typedef struct packed {
        logic country_bad;
        logic len_bad;
        logic char_bad;
    } ibanv_flags_t;

    // one classified character on its way through the queue
    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       head;
        logic       country_bad;
        logic       len_bad;
    } ibanv_item_t;

    // x < 1024 reduced mod 97; quotient estimate 168/2^14 is low by at most one
    function automatic logic [6:0] mod97_small(input logic [9:0] x);
        logic [17:0] prod;
        logic [9:0]  r;
        prod = 18'(x) * 18'd168;
        r    = x - 10'(prod[17:14]) * 10'(MODULUS);
        if (r >= 10'(MODULUS)) begin
            r = r - 10'(MODULUS);
        end
        return r[6:0];
    endfunction

    // x < 16384 reduced mod 97; quotient estimate 675/2^16 is low by at most one
    function automatic logic [6:0] mod97_wide(input logic [13:0] x);
        logic [23:0] prod;
        logic [13:0] r;
        prod = 24'(x) * 24'd675;
        r    = x - 14'(prod[23:16]) * 14'(MODULUS);
        if (r >= 14'(MODULUS)) begin
            r = r - 14'(MODULUS);
        end
        return r[6:0];
    endfunction

    // 10^k mod 97 for the digit count of the four head characters
    function automatic logic [6:0] pow10_mod97(input logic [3:0] k);
        logic [6:0] p;
        case (k)
            4'd0:    p = 7'd1;
            4'd1:    p = 7'd10;
            4'd2:    p = 7'd3;
            4'd3:    p = 7'd30;
            4'd4:    p = 7'd9;
            4'd5:    p = 7'd90;
            4'd6:    p = 7'd27;
            4'd7:    p = 7'd76;
            4'd8:    p = 7'd81;
            default: p = 7'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== sv/ibanv_front.sv =====
// Front end: accepts characters, tracks position, country and length checks.
module ibanv_front #(
    parameter int MAX_LENGTH = 34
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [6:0]           cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output ibanv_pkg::ibanv_item_t q_item
);

    logic [6:0] country_first_reg;
    logic [6:0] country_second_reg;
    logic [5:0] expected_length_reg;
    logic [5:0] count_reg, count_next;
    logic       country_bad_reg, country_bad_next;
    logic [5:0] count_inc;
    logic       hit;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    assign count_inc = (count_reg == ibanv_pkg::COUNT_MAX) ? count_reg : count_reg + 6'd1;
    assign hit = ((count_reg == 6'd0) && (s_tdata != {1'b0, country_first_reg})) ||
                 ((count_reg == 6'd1) && (s_tdata != {1'b0, country_second_reg}));

    always_comb begin
        q_item.character   = s_tdata;
        q_item.last        = s_tlast;
        q_item.head        = count_reg < ibanv_pkg::HEAD_CHARS;
        q_item.country_bad = country_bad_reg || hit;
        q_item.len_bad     = (count_inc != expected_length_reg) ||
                             (count_inc > 6'(MAX_LENGTH)) ||
                             (count_inc < ibanv_pkg::MIN_LENGTH);
    end

    always_comb begin
        count_next       = count_reg;
        country_bad_next = country_bad_reg;
        if (q_push) begin
            if (s_tlast) begin
                count_next       = 6'd0;
                country_bad_next = 1'b0;
            end else begin
                count_next       = count_inc;
                country_bad_next = country_bad_reg || hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg           <= 6'd0;
            country_bad_reg     <= 1'b0;
            country_first_reg   <= 7'd80;
            country_second_reg  <= 7'd76;
            expected_length_reg <= 6'd28;
        end else begin
            count_reg       <= count_next;
            country_bad_reg <= country_bad_next;
            if (cfg_we) begin
                case (cfg_index)
                    ibanv_pkg::CFG_COUNTRY_FIRST:   country_first_reg   <= cfg_wdata;
                    ibanv_pkg::CFG_COUNTRY_SECOND:  country_second_reg  <= cfg_wdata;
                    ibanv_pkg::CFG_EXPECTED_LENGTH: expected_length_reg <= cfg_wdata[5:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sv/ibanv_fifo.sv =====
// Short register queue between front and back.
module ibanv_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ibanv_pkg::ibanv_item_t din,
    output logic                   full,
    input  logic                   pop,
    output ibanv_pkg::ibanv_item_t dout,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ibanv_pkg::ibanv_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== sv/ibanv_back.sv =====
// Back end: mod-97 folding, rearrangement and status output register.
module ibanv_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ibanv_pkg::ibanv_item_t q_item,
    input  logic                   q_empty,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata
);

    // per-frame fold state
    logic [6:0] rem_reg, rem_next;
    logic [6:0] head_rem_reg, head_rem_next;
    logic [3:0] head_k_reg, head_k_next;
    logic       char_bad_reg, char_bad_next;

    // finishing pipeline
    logic                   s1_valid_reg;
    logic [6:0]             s1_rem_reg, s1_head_reg, s1_pow_reg;
    ibanv_pkg::ibanv_flags_t s1_flags_reg;
    logic                   s2_valid_reg;
    logic [13:0]            s2_prod_reg;
    ibanv_pkg::ibanv_flags_t s2_flags_reg;
    logic                   out_valid_reg;
    logic [2:0]             out_status_reg;
    logic [6:0]             out_rem_reg;

    logic       is_digit, is_letter;
    logic [5:0] char_val;
    logic [6:0] base, folded;
    logic [9:0] fold_in;
    logic       out_en, s2_en, s1_free;
    logic [6:0] final_rem;

    always_comb begin
        is_digit  = (q_item.character >= ibanv_pkg::CHAR_ZERO) &&
                    (q_item.character <= ibanv_pkg::CHAR_NINE);
        is_letter = (q_item.character >= ibanv_pkg::CHAR_A) &&
                    (q_item.character <= ibanv_pkg::CHAR_Z);
        char_val  = is_digit ? 6'(q_item.character - ibanv_pkg::CHAR_ZERO)
                             : 6'(q_item.character - ibanv_pkg::LETTER_OFFSET);
        base      = q_item.head ? head_rem_reg : rem_reg;
        // r*100 = r*3 mod 97
        fold_in   = is_digit ? 10'(base) * 10'd10 + 10'(char_val)
                             : 10'(base) * 10'd3 + 10'(char_val);
        folded    = ibanv_pkg::mod97_small(fold_in);
    end

    assign out_en  = s2_valid_reg && (!out_valid_reg || m_tready);
    assign s2_en   = s1_valid_reg && (!s2_valid_reg || out_en);
    assign s1_free = !s1_valid_reg || s2_en;
    assign q_pop   = !q_empty && (!q_item.last || s1_free);

    always_comb begin
        rem_next      = rem_reg;
        head_rem_next = head_rem_reg;
        head_k_next   = head_k_reg;
        char_bad_next = char_bad_reg || !(is_digit || is_letter);
        if (is_digit || is_letter) begin
            if (q_item.head) begin
                head_rem_next = folded;
                head_k_next   = head_k_reg + (is_digit ? 4'd1 : 4'd2);
            end else begin
                rem_next = folded;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg      <= 7'd0;
            head_rem_reg <= 7'd0;
            head_k_reg   <= 4'd0;
            char_bad_reg <= 1'b0;
        end else if (q_pop) begin
            if (q_item.last) begin
                rem_reg      <= 7'd0;
                head_rem_reg <= 7'd0;
                head_k_reg   <= 4'd0;
                char_bad_reg <= 1'b0;
            end else begin
                rem_reg      <= rem_next;
                head_rem_reg <= head_rem_next;
                head_k_reg   <= head_k_next;
                char_bad_reg <= char_bad_next;
            end
        end
    end

    // rearranged number = body * 10^k + head, all mod 97
    always_ff @(posedge aclk) begin
        if (q_pop && q_item.last) begin
            s1_rem_reg               <= rem_next;
            s1_head_reg              <= head_rem_next;
            s1_pow_reg               <= ibanv_pkg::pow10_mod97(head_k_next);
            s1_flags_reg.country_bad <= q_item.country_bad;
            s1_flags_reg.len_bad     <= q_item.len_bad;
            s1_flags_reg.char_bad    <= char_bad_next;
        end
        if (s2_en) begin
            s2_prod_reg  <= 14'(s1_rem_reg) * 14'(s1_pow_reg) + 14'(s1_head_reg);
            s2_flags_reg <= s1_flags_reg;
        end
    end

    assign final_rem = ibanv_pkg::mod97_wide(s2_prod_reg);

    always_ff @(posedge aclk) begin
        if (out_en) begin
            if (s2_flags_reg.country_bad) begin
                out_status_reg <= ibanv_pkg::ST_COUNTRY;
                out_rem_reg    <= 7'd0;
            end else if (s2_flags_reg.len_bad) begin
                out_status_reg <= ibanv_pkg::ST_LENGTH;
                out_rem_reg    <= 7'd0;
            end else if (s2_flags_reg.char_bad) begin
                out_status_reg <= ibanv_pkg::ST_BADCHAR;
                out_rem_reg    <= 7'd0;
            end else begin
                out_status_reg <= (final_rem == 7'd1) ? ibanv_pkg::ST_VALID
                                                      : ibanv_pkg::ST_CHECKSUM;
                out_rem_reg    <= final_rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop && q_item.last) begin
                s1_valid_reg <= 1'b1;
            end else if (s2_en) begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_en) begin
                s2_valid_reg <= 1'b1;
            end else if (out_en) begin
                s2_valid_reg <= 1'b0;
            end
            if (out_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_rem_reg, out_status_reg};

endmodule

// ===== sv/iban_mod97_validator_core.sv =====
// IBAN mod-97 validator top level: front end, queue, back end.
// Throughput: one character per cycle while m_tready keeps the result path moving, also across frame boundaries.
// The result reaches m_tvalid from the last character's transaction through the queue, s1
// (queue pop), s2 (rearrangement multiply) and the output register (final mod-97 reduction).
// The queue of QUEUE_DEPTH entries lets input and output stall independently.
// Reset (aresetn low, synchronous) clears stream state and queue and reloads the
// registers with 'P', 'L' and length 28.
module iban_mod97_validator_core #(
    parameter int MAX_LENGTH  = 34,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] status, [9:3] remainder, [15:10] zero
);

    ibanv_pkg::ibanv_item_t push_item, pop_item;
    logic q_push, q_pop, q_full, q_empty;

    ibanv_front #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    ibanv_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_item),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (pop_item),
        .empty   (q_empty)
    );

    ibanv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_item   (pop_item),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[9:3] < 7'd97))
        else $error("remainder out of range");

    a_valid_needs_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:0] == ibanv_pkg::ST_VALID)) |-> (m_tdata[9:3] == 7'd1))
        else $error("valid status without remainder one");

    a_rem_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ((m_tdata[2:0] == ibanv_pkg::ST_COUNTRY) ||
                      (m_tdata[2:0] == ibanv_pkg::ST_LENGTH) ||
                      (m_tdata[2:0] == ibanv_pkg::ST_BADCHAR))) |-> (m_tdata[9:3] == 7'd0))
        else $error("remainder not cleared on error status");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("queue written while full");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the IBAN mod-97 validator core.
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_LEN      = 34;
    localparam int LIMIT_CYCLES = 400000;

    // one status result as it appears in m_tdata[9:0]
    typedef struct packed {
        logic [6:0] remainder;
        logic [2:0] status;
    } mod97_verdict_t;

    class iban_scoreboard;
        logic [6:0]     country_first;
        logic [6:0]     country_second;
        logic [5:0]     expected_length;
        logic [6:0]     partial_rem;
        logic [5:0]     count;
        logic [7:0]     head [4];
        bit             country_bad;
        bit             char_bad;
        mod97_verdict_t verdicts [$];
        int             failures;
        int             chars;
        int             checked;
        int             status_seen [8];

        function new();
            country_first   = 7'd80;
            country_second  = 7'd76;
            expected_length = 6'd28;
            failures        = 0;
            chars           = 0;
            checked         = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            partial_rem = '0;
            count       = '0;
            foreach (head[i]) head[i] = '0;
            country_bad = 1'b0;
            char_bad    = 1'b0;
        endfunction

        function void set_regs(logic [6:0] first, logic [6:0] second, logic [5:0] len);
            country_first   = first;
            country_second  = second;
            expected_length = len;
        endfunction

        // digits append one decimal digit, capitals two; anything else flags bad
        function logic [6:0] fold_char(logic [6:0] rem, logic [7:0] c, inout bit bad);
            int r;
            r = rem;
            if (c >= ibanv_pkg::CHAR_ZERO && c <= ibanv_pkg::CHAR_NINE) begin
                r = (r * 10 + int'(c) - int'(ibanv_pkg::CHAR_ZERO)) % int'(ibanv_pkg::MODULUS);
            end else if (c >= ibanv_pkg::CHAR_A && c <= ibanv_pkg::CHAR_Z) begin
                r = (r * 100 + int'(c) - int'(ibanv_pkg::LETTER_OFFSET)) %
                    int'(ibanv_pkg::MODULUS);
            end else begin
                bad = 1'b1;
            end
            return r[6:0];
        endfunction

        function void note_char(logic [7:0] c, logic last);
            bit             bad;
            logic [6:0]     r;
            mod97_verdict_t v;
            bad = 1'b0;
            chars++;
            if (count < ibanv_pkg::HEAD_CHARS) begin
                head[count[1:0]] = c;
                r = fold_char(7'd0, c, bad);
                if (count == 6'd0 && c != {1'b0, country_first}) country_bad = 1'b1;
                if (count == 6'd1 && c != {1'b0, country_second}) country_bad = 1'b1;
            end else begin
                partial_rem = fold_char(partial_rem, c, bad);
            end
            if (bad) char_bad = 1'b1;
            if (count != ibanv_pkg::COUNT_MAX) count++;
            if (!last) return;

            v.remainder = '0;
            if (country_bad) begin
                v.status = ibanv_pkg::ST_COUNTRY;
            end else if (count != expected_length || count > MAX_LEN ||
                         count < ibanv_pkg::MIN_LENGTH) begin
                v.status = ibanv_pkg::ST_LENGTH;
            end else if (char_bad) begin
                v.status = ibanv_pkg::ST_BADCHAR;
            end else begin
                // rearranged number: head characters go behind the rest
                r = partial_rem;
                for (int i = 0; i < 4; i++) r = fold_char(r, head[i], bad);
                v.remainder = r;
                v.status    = (r == 7'd1) ? ibanv_pkg::ST_VALID : ibanv_pkg::ST_CHECKSUM;
            end
            verdicts.push_back(v);
            clear_frame();
        endfunction

        function void check_result(logic [15:0] data);
            mod97_verdict_t got;
            mod97_verdict_t want;
            got = data[9:0];
            if (verdicts.size() == 0) begin
                $error("unexpected result: status %0d remainder %0d", got.status, got.remainder);
                failures++;
                return;
            end
            want = verdicts.pop_front();
            if (got.status != want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
            if (got.remainder != want.remainder) begin
                $error("remainder: expected %0d, actual %0d", want.remainder, got.remainder);
                failures++;
            end
            if (data[15:10] != '0) begin
                $error("padding: expected 0, actual %0d", data[15:10]);
                failures++;
            end
            checked++;
            status_seen[want.status]++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] character
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [2:0] status, [9:3] remainder, [15:10] zero

    iban_scoreboard board = new();
    logic [7:0]     frame [$];
    bit             idle_on;
    int             cycles = 0;

    iban_mod97_validator_core #(.MAX_LENGTH(MAX_LEN)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("iban_mod97_validator_core: mismatch");
            $finish;
        end
    end

    // result side: random back-pressure bursts while idle_on is set
    initial begin : result_sink
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // country code, zero check digits, then the rest; check digits fixed up so
    // that the rearranged number leaves remainder 1
    function automatic void build_valid(int len, int letter_pct);
        logic [6:0] r;
        bit         dummy;
        int         chk;
        frame.delete();
        frame.push_back({1'b0, board.country_first});
        frame.push_back({1'b0, board.country_second});
        frame.push_back(ibanv_pkg::CHAR_ZERO);
        frame.push_back(ibanv_pkg::CHAR_ZERO);
        for (int i = 4; i < len; i++) begin
            if ($urandom_range(1, 100) <= letter_pct)
                frame.push_back(ibanv_pkg::CHAR_A + 8'($urandom_range(0, 25)));
            else
                frame.push_back(ibanv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        r = '0;
        dummy = 1'b0;
        for (int i = 4; i < len; i++) r = board.fold_char(r, frame[i], dummy);
        for (int i = 0; i < 4; i++) r = board.fold_char(r, frame[i], dummy);
        chk = 98 - int'(r);
        frame[2] = ibanv_pkg::CHAR_ZERO + 8'(chk / 10);
        frame[3] = ibanv_pkg::CHAR_ZERO + 8'(chk % 10);
    endfunction

    task automatic load_regs(logic [6:0] first, logic [6:0] second, logic [5:0] len);
        cfg_we    <= 1'b1;
        cfg_index <= ibanv_pkg::CFG_COUNTRY_FIRST;
        cfg_wdata <= first;
        @(posedge aclk);
        cfg_index <= ibanv_pkg::CFG_COUNTRY_SECOND;
        cfg_wdata <= second;
        @(posedge aclk);
        cfg_index <= ibanv_pkg::CFG_EXPECTED_LENGTH;
        cfg_wdata <= {1'b0, len};
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.set_regs(first, second, len);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++) begin
            if (idle_on && $urandom_range(0, 7) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame[i];
            s_tlast  <= (i == frame.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            board.note_char(frame[i], i == frame.size() - 1);
        end
    endtask

    // let every result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.verdicts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(logic [6:0] first, logic [6:0] second, logic [5:0] len,
                             int budget, bit idle);
        int         stop;
        int         pick;
        int         pos;
        int         n;
        logic [7:0] c;
        drain();
        load_regs(first, second, len);
        idle_on = idle;
        stop = board.chars + budget;
        while (board.chars < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                build_valid(len, 30);
            end else if (pick < 60) begin
                build_valid(len, 30);
                pos = $urandom_range(2, len - 1);
                c = ibanv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
                if (c == frame[pos])
                    c = ibanv_pkg::CHAR_ZERO +
                        8'((int'(c - ibanv_pkg::CHAR_ZERO) + 1) % 10);
                frame[pos] = c;
            end else if (pick < 70) begin
                build_valid(len, 30);
                do begin
                    c = 8'($urandom_range(0, 255));
                end while ((c >= ibanv_pkg::CHAR_ZERO && c <= ibanv_pkg::CHAR_NINE) ||
                           (c >= ibanv_pkg::CHAR_A && c <= ibanv_pkg::CHAR_Z));
                frame[$urandom_range(2, len - 1)] = c;
            end else if (pick < 78) begin
                build_valid(len, 30);
                frame[$urandom_range(0, 1)] = ibanv_pkg::CHAR_A + 8'($urandom_range(0, 25));
            end else if (pick < 88) begin
                n = int'(len) + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 3));
                if (n < 1) n = 1;
                build_valid((n < 4) ? 4 : n, 30);
                while (frame.size() > n) void'(frame.pop_back());
            end else if (pick < 96) begin
                // random bytes, half of them behind the right country code
                frame.delete();
                n = $urandom_range(1, 12);
                if ($urandom_range(0, 1)) begin
                    frame.push_back({1'b0, first});
                    frame.push_back({1'b0, second});
                end
                while (frame.size() < n) frame.push_back(8'($urandom_range(0, 255)));
            end else begin
                build_valid($urandom_range(35, 68), 30);
            end
            send_frame();
        end
    endtask

    initial begin : stimulus
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= ibanv_pkg::CFG_COUNTRY_FIRST;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        idle_on   = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: shortest legal length, every status, byte extremes
        load_regs(7'd80, 7'd76, 6'd5);
        build_valid(5, 0);
        send_frame();
        build_valid(5, 100);
        send_frame();
        frame.delete();
        frame.push_back("P");
        send_frame();
        frame.delete();
        frame.push_back(8'h00);
        send_frame();
        build_valid(5, 0);
        frame[4] = 8'hFF;
        send_frame();
        build_valid(5, 0);
        frame[3] = (frame[3] == ibanv_pkg::CHAR_NINE) ? ibanv_pkg::CHAR_ZERO : frame[3] + 8'd1;
        send_frame();
        frame.delete();
        frame.push_back("P");
        frame.push_back("X");
        send_frame();

        run_phase(7'd80, 7'd76, 6'd28, 250, 1'b1);
        run_phase(7'd65, 7'd65, 6'd5, 130, 1'b1);
        run_phase(7'd90, 7'd90, 6'd34, 200, 1'b1);
        run_phase(7'($urandom_range(65, 90)), 7'($urandom_range(65, 90)),
                  6'($urandom_range(5, 34)), 130, 1'b1);
        // count saturation against a length register the block can never accept
        run_phase(7'h7F, 7'h00, 6'd63, 130, 1'b1);
        run_phase(7'd68, 7'd69, 6'd22, 170, 1'b0);
        drain();

        $display("%0d characters sent, %0d results checked", board.chars, board.checked);
        $display("valid %0d, country %0d, length %0d, checksum %0d, bad character %0d",
                 board.status_seen[ibanv_pkg::ST_VALID],
                 board.status_seen[ibanv_pkg::ST_COUNTRY],
                 board.status_seen[ibanv_pkg::ST_LENGTH],
                 board.status_seen[ibanv_pkg::ST_CHECKSUM],
                 board.status_seen[ibanv_pkg::ST_BADCHAR]);
        if (board.failures == 0) begin
            $display("iban_mod97_validator_core: match");
        end else begin
            $display("iban_mod97_validator_core: mismatch");
        end
        $finish;
    end

endmodule
